// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/wspd_pkg.sv -----
package wspd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_FMT_SMALL = 3'd3,
        ST_NO_FMT    = 3'd4,
        ST_NO_DATA   = 3'd5,
        ST_BAD_DEPTH = 3'd6
    } t_status;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  sample;
        logic [31:0]  rate;
        logic [15:0]  channels;
        t_status      status;
        logic         final_flag;
    } t_result;

    // Results produced by one input beat: up to a sample and a status report.
    typedef struct packed {
        logic [1:0]        num;
        t_result [1:0]     item;
    } t_push;

endpackage

// ----- rtl/core/wspd_parser.sv -----
`include "assert_macros.svh"

module wspd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    output wspd_pkg::t_push   o_push
);

    typedef enum logic [2:0] {
        PH_RIFF   = 3'd0,
        PH_HEADER = 3'd1,
        PH_FMT    = 3'd2,
        PH_DATA   = 3'd3,
        PH_SKIP   = 3'd4,
        PH_PAD    = 3'd5,
        PH_HALT   = 3'd6
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [31:0]         r_pos, n_pos;
    logic [31:0]         r_tag, n_tag;
    logic [31:0]         r_len, n_len;
    logic [31:0]         r_rate, n_rate;
    logic [15:0]         r_chan, n_chan;
    logic [15:0]         r_depth, n_depth;
    logic                r_fmt, n_fmt;
    logic                r_data, n_data;
    logic [7:0]          r_low, n_low;
    wspd_pkg::t_status   r_err, n_err;

    logic [31:0]         pos_inc;
    logic                body_done;
    logic [31:0]         tag_shift;
    logic [31:0]         len_shift;
    logic                smp_valid;
    logic [15:0]         smp_value;
    wspd_pkg::t_status   status;
    wspd_pkg::t_result   res_smp;
    wspd_pkg::t_result   res_st;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_tag     = r_tag;
        n_len     = r_len;
        n_rate    = r_rate;
        n_chan    = r_chan;
        n_depth   = r_depth;
        n_fmt     = r_fmt;
        n_data    = r_data;
        n_low     = r_low;
        n_err     = r_err;
        smp_valid = 1'b0;
        smp_value = '0;
        pos_inc   = r_pos + 32'd1;
        body_done = (pos_inc == r_len);
        tag_shift = {r_tag[23:0], i_byte};
        len_shift = {i_byte, r_len[31:8]};

        if (i_valid) begin
            case (r_phase)
                PH_RIFF: begin
                    if (r_pos < 32'd4 || r_pos >= 32'd8) begin
                        n_tag = tag_shift;
                    end
                    if (r_pos == 32'd3 && n_tag != wspd_pkg::TAG_RIFF) begin
                        n_err = wspd_pkg::ST_NOT_WAVE;
                    end
                    if (r_pos == 32'd11) begin
                        if (n_tag != wspd_pkg::TAG_WAVE) begin
                            n_err = wspd_pkg::ST_NOT_WAVE;
                        end
                        n_pos   = '0;
                        n_phase = (n_err != wspd_pkg::ST_OK) ? PH_HALT : PH_HEADER;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_HEADER: begin
                    if (r_pos < 32'd4) begin
                        n_tag = tag_shift;
                    end else begin
                        n_len = len_shift;
                    end
                    if (r_pos == 32'd7) begin
                        n_pos = '0;
                        if (n_tag == wspd_pkg::TAG_FMT) begin
                            if (n_len < 32'd16) begin
                                n_err   = wspd_pkg::ST_FMT_SMALL;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase = r_data ? PH_SKIP : PH_FMT;
                            end
                        end else if (n_tag == wspd_pkg::TAG_DATA && !r_data && r_fmt) begin
                            n_data  = 1'b1;
                            n_low   = '0;
                            n_phase = (n_len == '0) ? PH_HEADER : PH_DATA;
                        end else begin
                            // empty body is even: straight back to a header
                            n_phase = (n_len == '0) ? PH_HEADER : PH_SKIP;
                        end
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_FMT: begin
                    if (r_pos == 32'd2) begin
                        n_chan[7:0] = i_byte;
                    end else if (r_pos == 32'd3) begin
                        n_chan[15:8] = i_byte;
                    end else if (r_pos >= 32'd4 && r_pos <= 32'd7) begin
                        n_rate[{r_pos[1:0], 3'b000} +: 8] = i_byte;
                    end else if (r_pos == 32'd14) begin
                        n_depth[7:0] = i_byte;
                    end else if (r_pos == 32'd15) begin
                        n_depth[15:8] = i_byte;
                        n_fmt         = 1'b1;
                    end
                    if (body_done) begin
                        n_pos   = '0;
                        n_phase = r_len[0] ? PH_PAD : PH_HEADER;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_DATA: begin
                    if (r_depth == 16'd16) begin
                        if (!r_pos[0]) begin
                            n_low = i_byte;
                        end else begin
                            smp_valid = 1'b1;
                            smp_value = {i_byte, r_low};
                        end
                    end else if (r_depth == 16'd8) begin
                        smp_valid = 1'b1;
                        smp_value = {~i_byte[7], i_byte[6:0], 8'h00};
                    end
                    if (body_done) begin
                        n_pos   = '0;
                        n_phase = r_len[0] ? PH_PAD : PH_HEADER;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_SKIP: begin
                    if (body_done) begin
                        n_pos   = '0;
                        n_phase = r_len[0] ? PH_PAD : PH_HEADER;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_PAD: begin
                    n_pos   = '0;
                    n_phase = PH_HEADER;
                end
                default: begin
                    // halt: drop bytes until end of file
                end
            endcase
        end
    end

    always_comb begin
        if (n_phase == PH_RIFF) begin
            status = wspd_pkg::ST_SHORT;
        end else if (n_err != wspd_pkg::ST_OK) begin
            status = n_err;
        end else if (!n_fmt) begin
            status = wspd_pkg::ST_NO_FMT;
        end else if (!n_data) begin
            status = wspd_pkg::ST_NO_DATA;
        end else if (n_depth != 16'd8 && n_depth != 16'd16) begin
            status = wspd_pkg::ST_BAD_DEPTH;
        end else begin
            status = wspd_pkg::ST_OK;
        end

        res_smp.kind       = wspd_pkg::KIND_SAMPLE;
        res_smp.sample     = smp_value;
        res_smp.rate       = n_rate;
        res_smp.channels   = n_chan;
        res_smp.status     = wspd_pkg::ST_OK;
        res_smp.final_flag = 1'b0;

        res_st.kind        = wspd_pkg::KIND_STATUS;
        res_st.sample      = '0;
        res_st.rate        = n_rate;
        res_st.channels    = n_chan;
        res_st.status      = status;
        res_st.final_flag  = 1'b1;

        o_push.num     = {1'b0, smp_valid} + {1'b0, i_valid & i_eof};
        o_push.item[0] = smp_valid ? res_smp : res_st;
        o_push.item[1] = res_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_eof)) begin
            r_phase <= PH_RIFF;
            r_pos   <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_rate  <= '0;
            r_chan  <= '0;
            r_depth <= '0;
            r_fmt   <= 1'b0;
            r_data  <= 1'b0;
            r_low   <= '0;
            r_err   <= wspd_pkg::ST_OK;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_rate  <= n_rate;
            r_chan  <= n_chan;
            r_depth <= n_depth;
            r_fmt   <= n_fmt;
            r_data  <= n_data;
            r_low   <= n_low;
            r_err   <= n_err;
        end
    end

    `ASSERT_CLK(a_eof_restarts, i_valid && i_eof |=> r_phase == PH_RIFF && r_pos == '0 && !r_fmt, "end of file did not restart the parser")
    `ASSERT_CLK(a_riff_pos, r_phase == PH_RIFF |-> r_pos < 32'd12, "file header position out of range")
    `ASSERT_CLK(a_two_results, o_push.num == 2'd2 |-> o_push.item[0].kind == wspd_pkg::KIND_SAMPLE && o_push.item[1].final_flag, "double result is not sample then status")

endmodule

// ----- rtl/core/wspd_result_fifo.sv -----
`include "assert_macros.svh"

module wspd_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wspd_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_ready,
    output logic                o_valid,
    output wspd_pkg::t_result   o_head
);

    wspd_pkg::t_result                 r_mem [wspd_pkg::QUEUE_DEPTH];
    logic [wspd_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [wspd_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [wspd_pkg::QUEUE_CW-1:0]     r_count;
    logic [wspd_pkg::QUEUE_AW-1:0]     wr_ptr_b;

    assign wr_ptr_b = r_wr_ptr + {{(wspd_pkg::QUEUE_AW-1){1'b0}}, 1'b1};
    // room for a sample plus a status report
    assign o_ready  = r_count <= wspd_pkg::QUEUE_CW'(wspd_pkg::QUEUE_DEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_head   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item[0];
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.item[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + wspd_pkg::QUEUE_AW'(i_push.num);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + {{(wspd_pkg::QUEUE_AW-1){1'b0}}, 1'b1};
            end
            r_count <= r_count + wspd_pkg::QUEUE_CW'(i_push.num)
                       - wspd_pkg::QUEUE_CW'(i_pop);
        end
    end

    `ASSERT_CLK(a_no_overflow, i_push.num != 2'd0 |-> r_count <= wspd_pkg::QUEUE_CW'(wspd_pkg::QUEUE_DEPTH - 2), "push without room")
    `ASSERT_CLK(a_ptr_track, r_wr_ptr == r_rd_ptr + r_count[wspd_pkg::QUEUE_AW-1:0], "pointers disagree with count")
    `ASSERT_CLK(a_no_underflow, i_pop |-> r_count != '0, "pop from empty queue")

endmodule

// ----- rtl/core/wav_stream_pcm_decoder_top.sv -----
// Latency: a result is queued the cycle after its byte is taken, behind earlier results.
// Throughput: one byte per cycle if the queue has room; state advances as each is taken.
// A four-entry result queue lets the slave side run while results wait to be taken;
// an end-of-file byte that also completes a sample makes two result beats.
// Reset: synchronous, active low; an end-of-file beat also resets the parser state.
module wav_stream_pcm_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // [15:0] pcm_sample, [47:16] rate_hz,
                                         // [63:48] channel_count, [66:64] status_code
    output logic         m_axis_tuser,   // [0] result_kind
    output logic         m_axis_tlast    // final_flag
);

    logic                s_accept;
    logic                m_accept;
    wspd_pkg::t_push     push;
    wspd_pkg::t_result   head;

    assign s_accept = s_axis_tvalid & s_axis_tready;
    assign m_accept = m_axis_tvalid & m_axis_tready;

    wspd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_byte  (s_axis_tdata),
        .i_eof   (s_axis_tlast),
        .o_push  (push)
    );

    wspd_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_accept),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {5'b00000, head.status, head.channels, head.rate, head.sample};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.final_flag;

endmodule
